/* rtl/pcrc_pkg.sv */
// shared types, constants and helpers for the point crop, rotate and classify block
// no dependencies; used by the interfaces and every module of the block
package pcrc_pkg;

    localparam int COORD_W       = 20;
    localparam int TRIG_W        = 18;
    localparam int LIMIT_W       = 19;
    localparam int CLASS_W       = 2;
    localparam int COUNT_W       = 16;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 20;
    localparam int PROD_W        = COORD_W + TRIG_W;
    localparam int SAT_IN_W      = PROD_W + 4;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN = -(1 << (COORD_W - 1));

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_COS_TILT    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIN_TILT    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Z    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_LIMIT_X = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_LIMIT_Y = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_LIMIT_Z = 4'd7;

    // point classes
    localparam logic [CLASS_W-1:0] CLASS_OUTSIDE  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_WHITE    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_RED_KEPT = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_RED_HIGH = 2'd3;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  cos_tilt;
        logic signed [TRIG_W-1:0]  sin_tilt;
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic signed [COORD_W-1:0] offset_z;
        logic [LIMIT_W-1:0]        box_limit_x;
        logic [LIMIT_W-1:0]        box_limit_y;
        logic [LIMIT_W-1:0]        box_limit_z;
    } cfg_t;

    typedef struct packed {
        logic                      in_box;
        logic                      row_end;
        logic signed [COORD_W-1:0] world_x;
        logic signed [PROD_W-1:0]  p_yc;
        logic signed [PROD_W-1:0]  p_zs;
        logic signed [PROD_W-1:0]  p_ys;
        logic signed [PROD_W-1:0]  p_zc;
    } prod_t;

    localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(COORD_MAX);
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = SAT_IN_W'(COORD_MIN);

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic signed [COORD_W-1:0] r;
        if (v > SAT_HI)
            r = COORD_W'(COORD_MAX);
        else if (v < SAT_LO)
            r = COORD_W'(COORD_MIN);
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

/* rtl/pcrc_point_if.sv */
// input channel: one camera point and its row-end flag
// depends on pcrc_pkg
interface pcrc_point_if;
    import pcrc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] cam_x;
    logic signed [COORD_W-1:0] cam_y;
    logic signed [COORD_W-1:0] cam_z;
    logic                      row_end;

    modport source (output valid, cam_x, cam_y, cam_z, row_end, input ready);
    modport sink (input valid, cam_x, cam_y, cam_z, row_end, output ready);
endinterface

/* rtl/pcrc_result_if.sv */
// result channel: world point, class and row counts
// depends on pcrc_pkg
interface pcrc_result_if;
    import pcrc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] world_x;
    logic signed [COORD_W-1:0] world_y;
    logic signed [COORD_W-1:0] world_z;
    logic [CLASS_W-1:0]        point_class;
    logic [COUNT_W-1:0]        red_total;
    logic [COUNT_W-1:0]        white_total;
    logic                      row_done;

    modport source (output valid, world_x, world_y, world_z, point_class, red_total,
                    white_total, row_done, input ready);
    modport sink (input valid, world_x, world_y, world_z, point_class, red_total,
                  white_total, row_done, output ready);
endinterface

/* rtl/pcrc_cfg_if.sv */
// configuration write channel: register index and write data
// depends on pcrc_pkg
interface pcrc_cfg_if;
    import pcrc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/point_crop_rotate_classify.sv */
// point crop, tilt transform and color classification, top level
// path: an accepted item passes the input, product and output registers in that order
// throughput: one item per cycle unless a stalled output backs up the three-stage pipeline
// reset: pipeline empty, row counters zero, registers at their default tilt and box
// depends on pcrc_pkg, the channel interfaces, pcrc_cfg_regs, pcrc_front and pcrc_back
module point_crop_rotate_classify #(
    parameter int FRAC_BITS = pcrc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    pcrc_point_if.sink    points,
    pcrc_result_if.source results,
    pcrc_cfg_if.sink      cfg
);
    import pcrc_pkg::*;

    cfg_t  regs;
    logic  s2_valid;
    logic  s2_ready;
    prod_t s2_data;

    pcrc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pcrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .points   (points),
        .regs     (regs),
        .s2_ready (s2_ready),
        .s2_valid (s2_valid),
        .s2_data  (s2_data)
    );

    pcrc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .regs     (regs),
        .s2_valid (s2_valid),
        .s2_data  (s2_data),
        .s2_ready (s2_ready),
        .results  (results)
    );

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.point_class == CLASS_OUTSIDE
        |-> results.world_x == '0 && results.world_y == '0 && results.world_z == '0)
        else $error("outside point with nonzero world value");

    a_red_counted: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.point_class == CLASS_RED_KEPT |-> results.red_total != '0)
        else $error("kept red point not counted");

    a_white_counted: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.point_class == CLASS_WHITE |-> results.white_total != '0)
        else $error("white point not counted");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !points.ready |-> results.valid && !results.ready)
        else $error("input stalled without output backpressure");

endmodule

/* rtl/pcrc_cfg_regs.sv */
// configuration register file with write decode
// depends on pcrc_pkg and pcrc_cfg_if
module pcrc_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    pcrc_cfg_if.sink         cfg,
    output pcrc_pkg::cfg_t   regs
);
    import pcrc_pkg::*;

    cfg_t regs_reg;
    logic wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.cos_tilt    <= TRIG_W'(65536);
            regs_reg.sin_tilt    <= '0;
            regs_reg.offset_x    <= '0;
            regs_reg.offset_y    <= '0;
            regs_reg.offset_z    <= '0;
            regs_reg.box_limit_x <= LIMIT_W'(9830);
            regs_reg.box_limit_y <= LIMIT_W'(13107);
            regs_reg.box_limit_z <= LIMIT_W'(45875);
        end
        else if (wr)
        begin
            unique case (cfg.index)
                REG_COS_TILT:    regs_reg.cos_tilt    <= cfg.data[TRIG_W-1:0];
                REG_SIN_TILT:    regs_reg.sin_tilt    <= cfg.data[TRIG_W-1:0];
                REG_OFFSET_X:    regs_reg.offset_x    <= cfg.data[COORD_W-1:0];
                REG_OFFSET_Y:    regs_reg.offset_y    <= cfg.data[COORD_W-1:0];
                REG_OFFSET_Z:    regs_reg.offset_z    <= cfg.data[COORD_W-1:0];
                REG_BOX_LIMIT_X: regs_reg.box_limit_x <= cfg.data[LIMIT_W-1:0];
                REG_BOX_LIMIT_Y: regs_reg.box_limit_y <= cfg.data[LIMIT_W-1:0];
                REG_BOX_LIMIT_Z: regs_reg.box_limit_z <= cfg.data[LIMIT_W-1:0];
                default:         regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

/* rtl/pcrc_front.sv */
// input register, box test, x transform and the four rotation products
// depends on pcrc_pkg and pcrc_point_if
module pcrc_front (
    input  logic            clk,
    input  logic            rst_n,
    pcrc_point_if.sink      points,
    input  pcrc_pkg::cfg_t  regs,
    input  logic            s2_ready,
    output logic            s2_valid,
    output pcrc_pkg::prod_t s2_data
);
    import pcrc_pkg::*;

    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] s1_x_reg;
    logic signed [COORD_W-1:0] s1_y_reg;
    logic signed [COORD_W-1:0] s1_z_reg;
    logic                      s1_row_end_reg;
    logic                      s2_valid_reg;
    prod_t                     s2_reg;
    prod_t                     s2_next;
    logic                      adv1;
    logic                      adv2;

    function automatic logic [COORD_W:0] mag(input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W:0] e;
        e = (COORD_W + 1)'(v);
        return v[COORD_W-1] ? (COORD_W + 1)'(-e) : (COORD_W + 1)'(e);
    endfunction

    assign adv2         = !s2_valid_reg || s2_ready;
    assign adv1         = !s1_valid_reg || adv2;
    assign points.ready = adv1;
    assign s2_valid     = s2_valid_reg;
    assign s2_data      = s2_reg;

    always_comb
    begin
        s2_next.in_box  = (mag(s1_x_reg) < (COORD_W + 1)'(regs.box_limit_x))
                       && (mag(s1_y_reg) < (COORD_W + 1)'(regs.box_limit_y))
                       && (mag(s1_z_reg) < (COORD_W + 1)'(regs.box_limit_z));
        s2_next.row_end = s1_row_end_reg;
        s2_next.world_x = sat_coord(SAT_IN_W'(regs.offset_x) - SAT_IN_W'(s1_x_reg));
        s2_next.p_yc    = PROD_W'(s1_y_reg) * PROD_W'(regs.cos_tilt);
        s2_next.p_zs    = PROD_W'(s1_z_reg) * PROD_W'(regs.sin_tilt);
        s2_next.p_ys    = PROD_W'(s1_y_reg) * PROD_W'(regs.sin_tilt);
        s2_next.p_zc    = PROD_W'(s1_z_reg) * PROD_W'(regs.cos_tilt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= points.valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && points.valid)
        begin
            s1_x_reg       <= points.cam_x;
            s1_y_reg       <= points.cam_y;
            s1_z_reg       <= points.cam_z;
            s1_row_end_reg <= points.row_end;
        end
        if (adv2 && s1_valid_reg)
            s2_reg <= s2_next;
    end

endmodule

/* rtl/pcrc_back.sv */
// rounding, offsets, saturation, classification, row counters and result register
// depends on pcrc_pkg and pcrc_result_if
module pcrc_back #(
    parameter int FRAC_BITS = pcrc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pcrc_pkg::cfg_t  regs,
    input  logic            s2_valid,
    input  pcrc_pkg::prod_t s2_data,
    output logic            s2_ready,
    pcrc_result_if.source   results
);
    import pcrc_pkg::*;

    localparam int SUM_W    = PROD_W + 2;
    localparam int HI_RED   = ((1 << FRAC_BITS) + 5) / 10;
    localparam int TOO_HIGH = (1 << FRAC_BITS) / 4;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] world_x_reg;
    logic signed [COORD_W-1:0] world_y_reg;
    logic signed [COORD_W-1:0] world_z_reg;
    logic [CLASS_W-1:0]        class_reg;
    logic [COUNT_W-1:0]        red_total_reg;
    logic [COUNT_W-1:0]        white_total_reg;
    logic                      row_done_reg;
    logic [COUNT_W-1:0]        red_reg;
    logic [COUNT_W-1:0]        white_reg;

    logic signed [SUM_W-1:0]   sum_y;
    logic signed [SUM_W-1:0]   sum_z;
    logic signed [SUM_W-1:0]   rnd_y;
    logic signed [SUM_W-1:0]   rnd_z;
    logic signed [COORD_W-1:0] wy;
    logic signed [COORD_W-1:0] wz;
    logic signed [COORD_W-1:0] world_x_next;
    logic signed [COORD_W-1:0] world_y_next;
    logic signed [COORD_W-1:0] world_z_next;
    logic [CLASS_W-1:0]        class_next;
    logic [COUNT_W-1:0]        red_next;
    logic [COUNT_W-1:0]        white_next;
    logic                      load;

    assign s2_ready = !out_valid_reg || results.ready;
    assign load     = s2_valid && s2_ready;

    always_comb
    begin
        sum_y = SUM_W'(s2_data.p_yc) + SUM_W'(s2_data.p_zs) + HALF;
        sum_z = SUM_W'(s2_data.p_ys) - SUM_W'(s2_data.p_zc) + HALF;
        rnd_y = sum_y >>> FRAC_BITS;
        rnd_z = sum_z >>> FRAC_BITS;
        wy    = sat_coord(SAT_IN_W'(rnd_y) + SAT_IN_W'(regs.offset_y));
        wz    = sat_coord(SAT_IN_W'(rnd_z) + SAT_IN_W'(regs.offset_z));

        if (!s2_data.in_box)
            class_next = CLASS_OUTSIDE;
        else if (int'(wz) > HI_RED)
            class_next = (int'(wz) < TOO_HIGH) ? CLASS_RED_KEPT : CLASS_RED_HIGH;
        else
            class_next = CLASS_WHITE;

        world_x_next = s2_data.in_box ? s2_data.world_x : '0;
        world_y_next = s2_data.in_box ? wy : '0;
        world_z_next = s2_data.in_box ? wz : '0;

        red_next   = red_reg;
        white_next = white_reg;
        if (class_next == CLASS_RED_KEPT && red_reg != COUNT_MAX)
            red_next = red_reg + COUNT_W'(1);
        if (class_next == CLASS_WHITE && white_reg != COUNT_MAX)
            white_next = white_reg + COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            red_reg       <= '0;
            white_reg     <= '0;
        end
        else
        begin
            if (s2_ready)
                out_valid_reg <= s2_valid;
            if (load)
            begin
                red_reg   <= s2_data.row_end ? '0 : red_next;
                white_reg <= s2_data.row_end ? '0 : white_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            world_x_reg     <= world_x_next;
            world_y_reg     <= world_y_next;
            world_z_reg     <= world_z_next;
            class_reg       <= class_next;
            red_total_reg   <= red_next;
            white_total_reg <= white_next;
            row_done_reg    <= s2_data.row_end;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.world_x     = world_x_reg;
    assign results.world_y     = world_y_reg;
    assign results.world_z     = world_z_reg;
    assign results.point_class = class_reg;
    assign results.red_total   = red_total_reg;
    assign results.white_total = white_total_reg;
    assign results.row_done    = row_done_reg;

endmodule
